FILE: design/nnir_pkg.sv
`default_nettype none

package nnir_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int FRAC_BITS   = 14;
  localparam int CFG_SIDE_W  = 9;
  localparam int ANGLE_W     = 16;
  localparam int PIXEL_W     = 32;
  localparam int DEST_W      = 9;
  localparam int DEST_LIMIT  = 512;
  localparam int DIM_W       = DEST_W + 1;
  localparam int SIDE_BITS   = $clog2(MAX_SIDE);
  localparam int ADDR_W      = 2 * SIDE_BITS;
  localparam int AREA_W      = ADDR_W + 1;
  localparam int CORNER_W    = CFG_SIDE_W + ANGLE_W + 2;
  localparam int OFF_W       = CORNER_W - FRAC_BITS;
  localparam int GPOS_W      = OFF_W + 1;
  localparam int PROD_W      = ANGLE_W + GPOS_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int QUOT_W      = SUM_W - FRAC_BITS;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = 2 * DEST_W + PIXEL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // The geometry pipeline behind the configuration registers has this many stages.
  localparam int GEOM_STAGES = 4;
  localparam int SETTLE_W    = $clog2(GEOM_STAGES + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COS_ANGLE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN_ANGLE       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_RGBA = 3'd4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic emit_accept;
    logic mul_en;
    logic sum_en;
    logic addr_en;
    logic rd_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic geom_empty;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/nnir_ctrl.sv
`default_nettype none

module nnir_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire                     in_tuser,
  input  wire                     cfg_we,
  input  nnir_pkg::dp_status_t    status,
  output nnir_pkg::ctrl_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  logic [2:0]                      state_r;
  logic [2:0]                      state_nxt;
  logic [nnir_pkg::SETTLE_W-1:0]   settle_r;
  logic [nnir_pkg::SETTLE_W-1:0]   settle_nxt;
  logic                            accept;

  assign in_tready = (state_r == ST_IDLE) && (settle_r == '0);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (cfg_we) begin
      settle_nxt = nnir_pkg::SETTLE_W'(nnir_pkg::GEOM_STAGES);
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == nnir_pkg::ACT_LOAD) begin
            cmd.load = 1'b1;
          end else if (!status.geom_empty) begin
            cmd.emit_accept = 1'b1;
            state_nxt       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      settle_r <= nnir_pkg::SETTLE_W'(nnir_pkg::GEOM_STAGES);
    end else begin
      state_r  <= state_nxt;
      settle_r <= settle_nxt;
    end
  end

  a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_accept |=> state_r == ST_MUL)
    else $error("accepted emit beat did not start the pipeline");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input taken before geometry settled");

  a_push_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) && status.out_free |=> state_r == ST_IDLE)
    else $error("controller stuck after result push");

  a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.emit_accept, cmd.mul_en, cmd.sum_en, cmd.addr_en,
              cmd.rd_en, cmd.out_load}))
    else $error("more than one datapath command at once");

endmodule

`default_nettype wire

FILE: design/nnir_dp.sv
`default_nettype none

module nnir_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [nnir_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [nnir_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire  [nnir_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  nnir_pkg::ctrl_cmd_t                   cmd,
  output nnir_pkg::dp_status_t                  status,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [nnir_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tuser,
  output logic                                  out_tlast
);

  localparam int CW = nnir_pkg::CORNER_W;
  localparam int FB = nnir_pkg::FRAC_BITS;

  logic [nnir_pkg::CFG_SIDE_W-1:0]        src_w_r;
  logic [nnir_pkg::CFG_SIDE_W-1:0]        src_h_r;
  logic signed [nnir_pkg::ANGLE_W-1:0]    cos_r;
  logic signed [nnir_pkg::ANGLE_W-1:0]    sin_r;
  logic [nnir_pkg::PIXEL_W-1:0]           bg_r;

  logic [nnir_pkg::CFG_SIDE_W-1:0]        w_cl;
  logic [nnir_pkg::CFG_SIDE_W-1:0]        h_cl;
  logic [nnir_pkg::CFG_SIDE_W-1:0]        w_cl_r;
  logic [nnir_pkg::CFG_SIDE_W-1:0]        h_cl_r;
  logic [nnir_pkg::AREA_W-1:0]            area_r;
  logic signed [CW-1:0]                   wc_r;
  logic signed [CW-1:0]                   hc_r;
  logic signed [CW-1:0]                   hs_r;
  logic signed [CW-1:0]                   ws_r;

  logic signed [CW-1:0]                   xs1_r;
  logic signed [CW-1:0]                   xs2_r;
  logic signed [CW-1:0]                   xs3_r;
  logic signed [CW-1:0]                   ys1_r;
  logic signed [CW-1:0]                   ys2_r;
  logic signed [CW-1:0]                   ys3_r;

  logic signed [CW-1:0]                   xmin_r;
  logic signed [CW-1:0]                   xmax_r;
  logic signed [CW-1:0]                   ymin_r;
  logic signed [CW-1:0]                   ymax_r;

  logic signed [CW:0]                     xmax_e;
  logic signed [CW:0]                     ymax_e;
  logic signed [nnir_pkg::OFF_W+1:0]      dx_full;
  logic signed [nnir_pkg::OFF_W+1:0]      dy_full;
  logic signed [nnir_pkg::OFF_W-1:0]      off_x_r;
  logic signed [nnir_pkg::OFF_W-1:0]      off_y_r;
  logic [nnir_pkg::DIM_W-1:0]             dw_r;
  logic [nnir_pkg::DIM_W-1:0]             dh_r;

  logic [nnir_pkg::ADDR_W-1:0]            pos_r;
  logic [nnir_pkg::AREA_W-1:0]            pos_inc;
  logic [nnir_pkg::PIXEL_W-1:0]           mem [0:(1 << nnir_pkg::ADDR_W)-1];

  logic [nnir_pkg::DEST_W-1:0]            col_r;
  logic [nnir_pkg::DEST_W-1:0]            row_r;
  logic [nnir_pkg::DIM_W-1:0]             col_inc;
  logic [nnir_pkg::DIM_W-1:0]             row_inc;
  logic                                   col_end;
  logic                                   row_end;

  logic [nnir_pkg::DEST_W-1:0]            dest_x_r;
  logic [nnir_pkg::DEST_W-1:0]            dest_y_r;
  logic                                   last_r;
  logic signed [nnir_pkg::GPOS_W-1:0]     gx_r;
  logic signed [nnir_pkg::GPOS_W-1:0]     gy_r;

  logic signed [nnir_pkg::PROD_W-1:0]     p_cx_r;
  logic signed [nnir_pkg::PROD_W-1:0]     p_sy_r;
  logic signed [nnir_pkg::PROD_W-1:0]     p_cy_r;
  logic signed [nnir_pkg::PROD_W-1:0]     p_sx_r;

  logic signed [nnir_pkg::SUM_W-1:0]      sum_x;
  logic signed [nnir_pkg::SUM_W-1:0]      sum_y;
  logic signed [nnir_pkg::QUOT_W-1:0]     qx;
  logic signed [nnir_pkg::QUOT_W-1:0]     qy;
  logic [nnir_pkg::SIDE_BITS-1:0]         sx_r;
  logic [nnir_pkg::SIDE_BITS-1:0]         sy_r;
  logic                                   inside_r;

  logic [nnir_pkg::ADDR_W-1:0]            addr_r;
  logic [nnir_pkg::PIXEL_W-1:0]           rdata_r;
  logic                                   out_valid_r;

  function automatic logic signed [CW-1:0] min4(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = '0;
    if (a < m) m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  function automatic logic signed [CW-1:0] max4(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic signed [CW-1:0] c);
    logic signed [CW-1:0] m;
    m = '0;
    if (a > m) m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnir_pkg::CFG_SIDE_W'(256);
      src_h_r <= nnir_pkg::CFG_SIDE_W'(256);
      cos_r   <= nnir_pkg::ANGLE_W'(16384);
      sin_r   <= '0;
      bg_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnir_pkg::REG_SOURCE_WIDTH:    src_w_r <= cfg_wdata[nnir_pkg::CFG_SIDE_W-1:0];
        nnir_pkg::REG_SOURCE_HEIGHT:   src_h_r <= cfg_wdata[nnir_pkg::CFG_SIDE_W-1:0];
        nnir_pkg::REG_COS_ANGLE:       cos_r   <= cfg_wdata[nnir_pkg::ANGLE_W-1:0];
        nnir_pkg::REG_SIN_ANGLE:       sin_r   <= cfg_wdata[nnir_pkg::ANGLE_W-1:0];
        nnir_pkg::REG_BACKGROUND_RGBA: bg_r    <= cfg_wdata[nnir_pkg::PIXEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (src_w_r == '0) begin
      w_cl = nnir_pkg::CFG_SIDE_W'(1);
    end else if (src_w_r > nnir_pkg::CFG_SIDE_W'(nnir_pkg::MAX_SIDE)) begin
      w_cl = nnir_pkg::CFG_SIDE_W'(nnir_pkg::MAX_SIDE);
    end else begin
      w_cl = src_w_r;
    end
    if (src_h_r == '0) begin
      h_cl = nnir_pkg::CFG_SIDE_W'(1);
    end else if (src_h_r > nnir_pkg::CFG_SIDE_W'(nnir_pkg::MAX_SIDE)) begin
      h_cl = nnir_pkg::CFG_SIDE_W'(nnir_pkg::MAX_SIDE);
    end else begin
      h_cl = src_h_r;
    end
  end

  // Geometry of the rotated frame, recomputed continuously from the registers.
  always_ff @(posedge clk) begin
    w_cl_r <= w_cl;
    h_cl_r <= h_cl;
    area_r <= nnir_pkg::AREA_W'(w_cl * h_cl);
    wc_r   <= CW'($signed({1'b0, w_cl}) * cos_r);
    hc_r   <= CW'($signed({1'b0, h_cl}) * cos_r);
    hs_r   <= CW'($signed({1'b0, h_cl}) * sin_r);
    ws_r   <= CW'($signed({1'b0, w_cl}) * sin_r);

    xs1_r  <= wc_r;
    xs2_r  <= wc_r - hs_r;
    xs3_r  <= -hs_r;
    ys1_r  <= hc_r;
    ys2_r  <= hc_r + ws_r;
    ys3_r  <= ws_r;

    xmin_r <= min4(xs1_r, xs2_r, xs3_r);
    xmax_r <= max4(xs1_r, xs2_r, xs3_r);
    ymin_r <= min4(ys1_r, ys2_r, ys3_r);
    ymax_r <= max4(ys1_r, ys2_r, ys3_r);

    off_x_r <= xmin_r[CW-1:FB];
    off_y_r <= ymin_r[CW-1:FB];
    if (dx_full > (nnir_pkg::OFF_W+2)'(nnir_pkg::DEST_LIMIT)) begin
      dw_r <= nnir_pkg::DIM_W'(nnir_pkg::DEST_LIMIT);
    end else begin
      dw_r <= dx_full[nnir_pkg::DIM_W-1:0];
    end
    if (dy_full > (nnir_pkg::OFF_W+2)'(nnir_pkg::DEST_LIMIT)) begin
      dh_r <= nnir_pkg::DIM_W'(nnir_pkg::DEST_LIMIT);
    end else begin
      dh_r <= dy_full[nnir_pkg::DIM_W-1:0];
    end
  end

  assign xmax_e  = (CW+1)'(xmax_r) + (CW+1)'((1 << FB) - 1);
  assign ymax_e  = (CW+1)'(ymax_r) + (CW+1)'((1 << FB) - 1);
  assign dx_full = (nnir_pkg::OFF_W+2)'(xmax_e[CW:FB]) -
                   (nnir_pkg::OFF_W+2)'($signed(xmin_r[CW-1:FB]));
  assign dy_full = (nnir_pkg::OFF_W+2)'(ymax_e[CW:FB]) -
                   (nnir_pkg::OFF_W+2)'($signed(ymin_r[CW-1:FB]));

  assign status.geom_empty = (dw_r == '0) || (dh_r == '0);
  assign status.out_free   = !out_valid_r || out_tready;

  assign pos_inc = {1'b0, pos_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.load) begin
      pos_r <= (pos_inc >= area_r) ? '0 : pos_inc[nnir_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[pos_r] <= in_tdata[nnir_pkg::PIXEL_W-1:0];
    end
  end

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign col_end = col_inc >= dw_r;
  assign row_end = row_inc >= dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.emit_accept) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_inc[nnir_pkg::DEST_W-1:0];
      end else begin
        col_r <= col_inc[nnir_pkg::DEST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_accept) begin
      dest_x_r <= col_r;
      dest_y_r <= row_r;
      last_r   <= col_end && row_end;
      gx_r     <= nnir_pkg::GPOS_W'($signed({1'b0, col_r})) + nnir_pkg::GPOS_W'(off_x_r);
      gy_r     <= nnir_pkg::GPOS_W'($signed({1'b0, row_r})) + nnir_pkg::GPOS_W'(off_y_r);
    end
    if (cmd.mul_en) begin
      p_cx_r <= cos_r * gx_r;
      p_sy_r <= sin_r * gy_r;
      p_cy_r <= cos_r * gy_r;
      p_sx_r <= sin_r * gx_r;
    end
    if (cmd.sum_en) begin
      sx_r     <= qx[nnir_pkg::SIDE_BITS-1:0];
      sy_r     <= qy[nnir_pkg::SIDE_BITS-1:0];
      inside_r <= !qx[nnir_pkg::QUOT_W-1] && !qy[nnir_pkg::QUOT_W-1] &&
                  (qx < $signed(nnir_pkg::QUOT_W'(w_cl_r))) &&
                  (qy < $signed(nnir_pkg::QUOT_W'(h_cl_r)));
    end
    if (cmd.addr_en) begin
      addr_r <= nnir_pkg::ADDR_W'(sy_r * w_cl_r + nnir_pkg::ADDR_W'(sx_r));
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr_r];
    end
  end

  // Division by the fixed-point scale rounds toward zero.
  always_comb begin
    sum_x = nnir_pkg::SUM_W'(p_cx_r) + nnir_pkg::SUM_W'(p_sy_r);
    sum_y = nnir_pkg::SUM_W'(p_cy_r) - nnir_pkg::SUM_W'(p_sx_r);
    qx    = sum_x[nnir_pkg::SUM_W-1:FB];
    qy    = sum_y[nnir_pkg::SUM_W-1:FB];
    if (sum_x[nnir_pkg::SUM_W-1] && (sum_x[FB-1:0] != '0)) begin
      qx = qx + 1'b1;
    end
    if (sum_y[nnir_pkg::SUM_W-1] && (sum_y[FB-1:0] != '0)) begin
      qy = qy + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= nnir_pkg::OUT_TDATA_W'({inside_r ? rdata_r : bg_r, dest_y_r, dest_x_r});
      out_tuser <= inside_r;
      out_tlast <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: design/nearest_neighbor_image_rotator.sv
// Nearest-neighbor rotation of a stored RGBA image about its top-left corner.
// The input channel carries one beat per item: in_tuser selects load (0) or
// emit (1), and in_tdata holds the source pixel for a load. Loads fill the
// source memory in raster order and produce no output beat. Each emit beat
// produces one output beat with the next destination pixel in raster order,
// or nothing when the rotated frame is empty.
// An emit runs through coordinate products, sum and truncation, address multiply
// and one memory read before its result is loaded into the output register, and
// the next input beat is not taken until that result has been pushed there.
// Only one emit is in flight; the source memory has one read and one write port.
// After reset, and after each configuration write, in_tready stays low while the
// frame geometry pipeline settles. Reset returns the registers to a 256 by 256
// source, an unrotated angle and a black background, and the load and emit
// positions to zero; the memory contents are not cleared.
// When the receiver stalls, the result beat is held in the output register, and
// the next emit waits until that register can be reloaded.
`default_nettype none

module nearest_neighbor_image_rotator (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [nnir_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [nnir_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [nnir_pkg::IN_TDATA_W-1:0]       in_tdata,   // source_pixel
  input  wire                                   in_tuser,   // action
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [nnir_pkg::OUT_TDATA_W-1:0]      out_tdata,  // dest_x, dest_y, dest_pixel
  output logic                                  out_tuser,  // from_source
  output logic                                  out_tlast
);

  nnir_pkg::ctrl_cmd_t  cmd;
  nnir_pkg::dp_status_t status;

  nnir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .status    (status),
    .cmd       (cmd)
  );

  nnir_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: test/nearest_neighbor_image_rotator_tb.sv
module nearest_neighbor_image_rotator_tb;
  import nnir_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TARGET_ITEMS  = 1550;
  localparam int HOLD_CYCLES   = 300;
  localparam int PAD_LO        = 2 * DEST_W + PIXEL_W;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;

  typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_e;

  typedef struct packed {
    logic               action;
    logic [PIXEL_W-1:0] pixel;
  } pixel_cmd_t;

  typedef struct packed {
    logic [DEST_W-1:0]  x;
    logic [DEST_W-1:0]  y;
    logic [PIXEL_W-1:0] pixel;
    logic               from_src;
    logic               last;
  } dest_pix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  nearest_neighbor_image_rotator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  logic [CFG_SIDE_W-1:0]     reg_width  = 9'd256;
  logic [CFG_SIDE_W-1:0]     reg_height = 9'd256;
  logic signed [ANGLE_W-1:0] reg_cos    = 16'sd16384;
  logic signed [ANGLE_W-1:0] reg_sin    = '0;
  logic [PIXEL_W-1:0]        reg_bg     = '0;
  logic [PIXEL_W-1:0]        src_mem [0:MAX_SIDE*MAX_SIDE-1];
  int load_pos = 0;
  int emit_col = 0;
  int emit_row = 0;
  int written_prefix = 0;

  pixel_cmd_t pixel_cmd_q[$];
  dest_pix_t  dest_pix_q[$];
  dest_pix_t  got_pix;
  dest_pix_t  want_pix;

  gap_mode_e gap_mode = GAP_NONE;
  bit in_fire = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  int errors = 0;
  int total_items = 0;
  int n_loads = 0;
  int n_emits = 0;
  int n_checked = 0;
  int n_from_src = 0;
  int n_last = 0;
  int n_settings = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int side_of(logic [CFG_SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // Updates the image state for one accepted beat and queues any pixel it yields.
  task automatic rotate_predict(input pixel_cmd_t cmd);
    int w, h, i, nxt;
    longint c, s, one, xmin, xmax, ymin, ymax, off_x, off_y, dw, dh, gx, gy, sx, sy;
    longint cx[4];
    longint cy[4];
    dest_pix_t res;
    w = side_of(reg_width);
    h = side_of(reg_height);
    c = longint'(reg_cos);
    s = longint'(reg_sin);
    if (cmd.action == ACT_LOAD) begin
      src_mem[load_pos] = cmd.pixel;
      if (load_pos == written_prefix) written_prefix++;
      nxt = load_pos + 1;
      load_pos = (nxt >= w * h) ? 0 : nxt;
      n_loads++;
      return;
    end
    n_emits++;
    cx[0] = 0;             cy[0] = 0;
    cx[1] = w * c;         cy[1] = h * c;
    cx[2] = w * c - h * s; cy[2] = h * c + w * s;
    cx[3] = -h * s;        cy[3] = w * s;
    xmin = 0; xmax = 0; ymin = 0; ymax = 0;
    for (i = 1; i < 4; i++) begin
      if (cx[i] < xmin) xmin = cx[i];
      if (cx[i] > xmax) xmax = cx[i];
      if (cy[i] < ymin) ymin = cy[i];
      if (cy[i] > ymax) ymax = cy[i];
    end
    // Arithmetic shift floors; the ceiling is the negated floor of the negation.
    off_x = xmin >>> FRAC_BITS;
    off_y = ymin >>> FRAC_BITS;
    dw = -((-xmax) >>> FRAC_BITS) - off_x;
    dh = -((-ymax) >>> FRAC_BITS) - off_y;
    if (dw > DEST_LIMIT) dw = DEST_LIMIT;
    if (dh > DEST_LIMIT) dh = DEST_LIMIT;
    if (dw <= 0 || dh <= 0) return;
    one = longint'(1) << FRAC_BITS;
    gx = emit_col + off_x;
    gy = emit_row + off_y;
    sx = (c * gx + s * gy) / one;
    sy = (c * gy - s * gx) / one;
    res.x = emit_col[DEST_W-1:0];
    res.y = emit_row[DEST_W-1:0];
    res.from_src = sx >= 0 && sy >= 0 && sx < w && sy < h;
    res.pixel = res.from_src ? src_mem[sy * w + sx] : reg_bg;
    res.last = (emit_col + 1 >= dw) && (emit_row + 1 >= dh);
    dest_pix_q.push_back(res);
    if (emit_col + 1 >= dw) begin
      emit_col = 0;
      emit_row = (emit_row + 1 >= dh) ? 0 : emit_row + 1;
    end else begin
      emit_col++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    if (errors < 30) begin
      $display("%s mismatch at pixel %0d: got %0h, want %0h", what, n_checked, got, want);
    end
    errors++;
  endtask

  function automatic void queue_cmd(logic act);
    pixel_cmd_t cmd;
    cmd.action = act;
    case ($urandom_range(0, 9))
      0: cmd.pixel = '0;
      1: cmd.pixel = '1;
      default: cmd.pixel = $urandom;
    endcase
    pixel_cmd_q.push_back(cmd);
    total_items++;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SOURCE_WIDTH:    reg_width  = data[CFG_SIDE_W-1:0];
      REG_SOURCE_HEIGHT:   reg_height = data[CFG_SIDE_W-1:0];
      REG_COS_ANGLE:       reg_cos    = data[ANGLE_W-1:0];
      REG_SIN_ANGLE:       reg_sin    = data[ANGLE_W-1:0];
      REG_BACKGROUND_RGBA: reg_bg     = data[PIXEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_cmd_q.size() != 0 || dest_pix_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register setting: program it, load a full frame if the stored image
  // does not yet cover the new size, then a random mix of emits and loads.
  task automatic run_phase(input logic [31:0] w_data, input logic [31:0] h_data,
                           input logic [31:0] cos_data, input logic [31:0] sin_data,
                           input logic [31:0] bg_data, input gap_mode_e mode,
                           input int body_len, input int emit_pct, input bit squeeze);
    int area, lead;
    wait_idle();
    gap_mode = mode;
    write_reg(REG_SOURCE_WIDTH, w_data);
    write_reg(REG_SOURCE_HEIGHT, h_data);
    write_reg(REG_COS_ANGLE, cos_data);
    write_reg(REG_SIN_ANGLE, sin_data);
    write_reg(REG_BACKGROUND_RGBA, bg_data);
    if (n_settings == 3 || $urandom_range(0, 5) == 0) write_reg(REG_NONE, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
    area = side_of(reg_width) * side_of(reg_height);
    if (area > written_prefix) begin
      lead = (load_pos == 0) ? 0 : (load_pos >= area) ? 1 : area - load_pos;
      repeat (lead + area) queue_cmd(ACT_LOAD);
    end
    hold_armed = squeeze;
    repeat (body_len) queue_cmd(($urandom_range(1, 100) <= emit_pct) ? ACT_EMIT : ACT_LOAD);
  endtask

  always @(posedge clk) begin
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      rotate_predict(pixel_cmd_q[0]);
      void'(pixel_cmd_q.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pixel_cmd_q.size() != 0 &&
          !((gap_mode == GAP_SENDER && $urandom_range(0, 99) < 79) ||
            (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 21))) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pixel_cmd_q[0].pixel;
        in_tuser  <= pixel_cmd_q[0].action;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The receiver holds off once for a long stretch so the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_armed && !hold_used && out_tvalid) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !((gap_mode == GAP_RECEIVER && $urandom_range(0, 99) < 79) ||
                      (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 21));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_pix.x        = out_tdata[DEST_W-1:0];
      got_pix.y        = out_tdata[2*DEST_W-1:DEST_W];
      got_pix.pixel    = out_tdata[PAD_LO-1:2*DEST_W];
      got_pix.from_src = out_tuser;
      got_pix.last     = out_tlast;
      if (dest_pix_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, '0);
      end else begin
        want_pix = dest_pix_q.pop_front();
        if (got_pix.x != want_pix.x) report_mismatch("dest_x", got_pix.x, want_pix.x);
        if (got_pix.y != want_pix.y) report_mismatch("dest_y", got_pix.y, want_pix.y);
        if (got_pix.pixel != want_pix.pixel)
          report_mismatch("dest_pixel", got_pix.pixel, want_pix.pixel);
        if (got_pix.from_src != want_pix.from_src)
          report_mismatch("from_source", got_pix.from_src, want_pix.from_src);
        if (got_pix.last != want_pix.last) report_mismatch("last", got_pix.last, want_pix.last);
        if (out_tdata[OUT_TDATA_W-1:PAD_LO] != '0)
          report_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:PAD_LO], '0);
        n_checked++;
        if (want_pix.from_src) n_from_src++;
        if (want_pix.last) n_last++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int p;
    logic [31:0] wv, hv, bgv;
    logic [15:0] ca, sa;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // A single pixel makes every emit the end of its frame.
    run_phase(32'd1, 32'd1, 32'h4000, 32'h0, 32'hFFFF_FFFF, GAP_NONE, 3, 100, 1'b0);
    run_phase(32'd2, 32'd2, 32'h0, 32'h4000, 32'h0, GAP_NONE, 5, 100, 1'b0);
    // Zero width saturates to one column; half a turn.
    run_phase(32'd0, 32'd3, 32'hC000, 32'h0, 32'h5A5A_A5A5, GAP_NONE, 3, 100, 1'b0);
    // Zero angle registers collapse the destination to nothing.
    run_phase(32'd3, 32'd2, 32'h0, 32'h0, 32'h1234_5678, GAP_NONE, 2, 100, 1'b0);
    run_phase(32'd2, 32'd2, 32'd11585, 32'h0000_D2BF, 32'hDEAD_BEEF, GAP_NONE, 6, 100, 1'b0);

    for (p = 0; total_items < TARGET_ITEMS; p++) begin
      wv = $urandom_range(1, 12);
      hv = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) wv = 0;
      if ($urandom_range(0, 7) == 0) hv = 0;
      case ($urandom_range(0, 9))
        0: begin ca = 16'h4000; sa = 16'h0000; end
        1: begin ca = 16'h0000; sa = 16'h4000; end
        2: begin ca = 16'hC000; sa = 16'h0000; end
        3: begin ca = 16'h0000; sa = 16'hC000; end
        4: begin ca = 16'd11585; sa = 16'd11585; end
        5: begin ca = 16'd11585; sa = 16'hD2BF; end
        6: begin ca = 16'hD2BF; sa = 16'd11585; end
        9: begin
          case ($urandom_range(0, 2))
            0: begin ca = 16'h0000; sa = 16'h0000; end
            1: begin ca = 16'h7FFF; sa = 16'h8000; end
            default: begin ca = 16'h8000; sa = $urandom; end
          endcase
        end
        default: begin
          ca = 16'($urandom_range(0, 32768) - 16384);
          sa = 16'($urandom_range(0, 32768) - 16384);
        end
      endcase
      case ($urandom_range(0, 4))
        0: bgv = '0;
        1: bgv = '1;
        default: bgv = $urandom;
      endcase
      // Wide sources at out-of-range angles push the destination past its limit.
      if (p == 1) begin wv = 32'h1FF; hv = 1; ca = 16'h8000; sa = 16'h8000; end
      if (p == 2) begin wv = 1; hv = 256; ca = 16'h0000; sa = 16'hC000; end
      if (p == 6) begin wv = 256; hv = 0; ca = 16'h7FFF; sa = 16'h7FFF; end
      if ($urandom_range(0, 3) == 0) wv = wv | ($urandom & 32'hFFFF_FE00);
      if ($urandom_range(0, 3) == 0) hv = hv | ($urandom & 32'hFFFF_FE00);
      run_phase(wv, hv,
                {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0, ca},
                {($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0, sa},
                bgv, gap_mode_e'(p % 4),
                (p == 0) ? 60 : $urandom_range(20, 70),
                (p == 0) ? 90 : $urandom_range(45, 90),
                p == 0);
    end

    wait_idle();
    $display("Run covered %0d register settings with %0d pixel loads and %0d emit requests.",
             n_settings, n_loads, n_emits);
    $display("Checked %0d rotated pixels: %0d from the source, %0d background, %0d frame ends.",
             n_checked, n_from_src, n_checked - n_from_src, n_last);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
